// ===== design/tis_pkg.sv =====
// ----------------------------------------------------------------------------
// tis_pkg
// Types and constants shared by the triangle isoline segment pipeline.
// ----------------------------------------------------------------------------
package tis_pkg;

  localparam int unsigned CoordW = 24;                // Q16.8 and Q12.12 fields
  localparam int unsigned WgtW   = CoordW + 1;        // |level - scalar|
  localparam int unsigned DenW   = WgtW + 1;          // sum of two weights
  localparam int unsigned ProdW  = CoordW + DenW;     // coordinate times weight
  localparam int unsigned NumW   = ProdW;             // rounded magnitude
  localparam int unsigned QuoW   = CoordW + 1;        // quotient magnitude
  localparam int unsigned NumLanes = 6;               // start x,y,z then end x,y,z
  // Classify, product, sum, QuoW divider stages, output register.
  localparam int unsigned Latency = 4 + QuoW;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [WgtW-1:0]          wgt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t value;
  } vertex_t;

  // One output point: (p * wq + q * wp) / (wp + wq) on every axis.
  typedef struct packed {
    coord_t [2:0] p;
    coord_t [2:0] q;
    wgt_t         wp;
    wgt_t         wq;
  } xing_t;

  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } lane_t;

endpackage

// ===== design/tis_classify.sv =====
// ----------------------------------------------------------------------------
// tis_classify
// Classes the vertices against the level and selects the two output points.
// ----------------------------------------------------------------------------
module tis_classify (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  tis_pkg::coord_t          level_i,
  input  tis_pkg::vertex_t [2:0]   vtx_i,
  output logic                     vld_o,
  output tis_pkg::xing_t   [1:0]   seg_o
);
  import tis_pkg::*;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LONE,
    KIND_APEX,
    KIND_EDGE
  } kind_e;

  logic [2:0]            on_v, ab_v, be_v;
  wgt_t [2:0]            w;
  logic [1:0]            n_on, n_ab, n_be;
  kind_e                 kind;
  logic [1:0]            pick, o1, o2;
  logic                  vld_d, vld_q;
  xing_t [1:0]           seg_d, seg_q;

  function automatic logic [1:0] first_set(input logic [2:0] m);
    logic [1:0] r;
    r = 2'd2;
    if (m[1]) r = 2'd1;
    if (m[0]) r = 2'd0;
    return r;
  endfunction

  function automatic xing_t direct(input vertex_t v);
    xing_t r;
    r.p  = {v.x, v.y, v.z};
    r.q  = {v.x, v.y, v.z};
    r.wp = '0;
    r.wq = WgtW'(1);
    return r;
  endfunction

  always_comb begin
    logic signed [WgtW-1:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff    = {vtx_i[i].value[CoordW-1], vtx_i[i].value} - {level_i[CoordW-1], level_i};
      on_v[i] = (vtx_i[i].value == level_i);
      ab_v[i] = ($signed(vtx_i[i].value) > $signed(level_i));
      be_v[i] = !on_v[i] && !ab_v[i];
      w[i]    = ab_v[i] ? wgt_t'(diff) : wgt_t'(-diff);
    end
    n_on = 2'($countones(on_v));
    n_ab = 2'($countones(ab_v));
    n_be = 2'($countones(be_v));

    kind = KIND_NONE;
    pick = 2'd0;
    if (n_ab == 2'd1 && n_be == 2'd2) begin
      kind = KIND_LONE;
      pick = first_set(ab_v);
    end else if (n_be == 2'd1 && n_ab == 2'd2) begin
      kind = KIND_LONE;
      pick = first_set(be_v);
    end else if (n_on == 2'd1 && n_ab == 2'd1) begin
      kind = KIND_APEX;
      pick = first_set(on_v);
    end else if (n_on == 2'd2) begin
      kind = KIND_EDGE;
      pick = first_set(~on_v);
    end
    o1 = (pick == 2'd0) ? 2'd1 : 2'd0;
    o2 = (pick == 2'd2) ? 2'd1 : 2'd2;

    seg_d[0] = direct(vtx_i[o1]);
    seg_d[1] = direct(vtx_i[o2]);
    case (kind)
      KIND_LONE: begin
        seg_d[0].p  = {vtx_i[pick].x, vtx_i[pick].y, vtx_i[pick].z};
        seg_d[0].q  = {vtx_i[o1].x, vtx_i[o1].y, vtx_i[o1].z};
        seg_d[0].wp = w[pick];
        seg_d[0].wq = w[o1];
        seg_d[1].p  = {vtx_i[pick].x, vtx_i[pick].y, vtx_i[pick].z};
        seg_d[1].q  = {vtx_i[o2].x, vtx_i[o2].y, vtx_i[o2].z};
        seg_d[1].wp = w[pick];
        seg_d[1].wq = w[o2];
      end
      KIND_APEX: begin
        seg_d[0]    = direct(vtx_i[pick]);
        seg_d[1].p  = {vtx_i[o1].x, vtx_i[o1].y, vtx_i[o1].z};
        seg_d[1].q  = {vtx_i[o2].x, vtx_i[o2].y, vtx_i[o2].z};
        seg_d[1].wp = w[o1];
        seg_d[1].wq = w[o2];
      end
      default: ;
    endcase
    vld_d = vld_i && (kind != KIND_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign vld_o = vld_q;
  assign seg_o = seg_q;

endmodule

// ===== design/tis_interp.sv =====
// ----------------------------------------------------------------------------
// tis_interp
// Weighted sums and rounding offset for the six output coordinates.
// ----------------------------------------------------------------------------
module tis_interp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    vld_i,
  input  tis_pkg::xing_t [1:0]                    seg_i,
  output logic                                    vld_o,
  output tis_pkg::lane_t [tis_pkg::NumLanes-1:0]  lanes_o
);
  import tis_pkg::*;

  logic signed [ProdW-1:0] prod_p_q [NumLanes];
  logic signed [ProdW-1:0] prod_q_q [NumLanes];
  logic [DenW-1:0]         den_q    [NumLanes];
  logic                    vld_a_q, vld_b_q;
  lane_t [NumLanes-1:0]    lanes_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      prod_p_q[l] <= $signed(seg_i[l/3].p[2-(l%3)]) * $signed({1'b0, seg_i[l/3].wq});
      prod_q_q[l] <= $signed(seg_i[l/3].q[2-(l%3)]) * $signed({1'b0, seg_i[l/3].wp});
      den_q[l]    <= DenW'(seg_i[l/3].wp) + DenW'(seg_i[l/3].wq);
    end
  end

  // The weighted sum is at most 2^48 in magnitude, so the rounded value fits.
  always_ff @(posedge clk_i) begin
    logic signed [ProdW:0] sum;
    logic [ProdW:0]        mag;
    for (int l = 0; l < NumLanes; l++) begin
      sum = {prod_p_q[l][ProdW-1], prod_p_q[l]} + {prod_q_q[l][ProdW-1], prod_q_q[l]};
      mag = sum[ProdW] ? (ProdW+1)'(-sum) : (ProdW+1)'(sum);
      lanes_q[l].neg <= sum[ProdW];
      lanes_q[l].rem <= mag[NumW-1:0] + NumW'(den_q[l] >> 1);
      lanes_q[l].den <= den_q[l];
      lanes_q[l].quo <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  assign vld_o   = vld_b_q;
  assign lanes_o = lanes_q;

endmodule

// ===== design/tis_div.sv =====
// ----------------------------------------------------------------------------
// tis_div
// Restoring divider, one quotient bit per pipeline stage, for all six lanes.
// ----------------------------------------------------------------------------
module tis_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    vld_i,
  input  tis_pkg::lane_t [tis_pkg::NumLanes-1:0]  lanes_i,
  output logic                                    vld_o,
  output tis_pkg::lane_t [tis_pkg::NumLanes-1:0]  lanes_o
);
  import tis_pkg::*;

  lane_t [NumLanes-1:0] st_q [QuoW];
  logic  [QuoW-1:0]     vld_q;

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - s;
    lane_t [NumLanes-1:0] prev;
    lane_t [NumLanes-1:0] nxt;

    if (s == 0) begin : g_first
      assign prev = lanes_i;
    end else begin : g_rest
      assign prev = st_q[s-1];
    end

    always_comb begin
      logic [NumW-1:0] dsh;
      for (int l = 0; l < NumLanes; l++) begin
        dsh    = NumW'(prev[l].den) << Bit;
        nxt[l] = prev[l];
        if (prev[l].rem >= dsh) begin
          nxt[l].rem      = prev[l].rem - dsh;
          nxt[l].quo[Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= nxt;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (s == 0) begin
        vld_q[s] <= vld_i;
      end else begin
        vld_q[s] <= vld_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign vld_o   = vld_q[QuoW-1];
  assign lanes_o = st_q[QuoW-1];

endmodule

// ===== design/triangle_isoline_segment.sv =====
// ----------------------------------------------------------------------------
// triangle_isoline_segment
// Marching-triangles isoline extraction: one triangle in, at most one segment
// out, with crossings interpolated and rounded to nearest.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  input     start / busy           a_*, b_*, c_* vertex coordinates and scalars
//  result    done_o strobe          start_x/y/z_o, end_x/y/z_o
//  config    iso_level_we_i         iso_level_i
//
//  A triangle is taken in every cycle; busy never rises.
//  A segment appears on done_o after its triangle has passed classification,
//  two interpolation stages, 25 divider stages (one quotient bit each) and
//  the output register.
//  Reset clears the valid bits and sets the level to zero.
//  The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module triangle_isoline_segment (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            iso_level_we_i,
  input  tis_pkg::coord_t iso_level_i,
  input  tis_pkg::coord_t a_x_i,
  input  tis_pkg::coord_t a_y_i,
  input  tis_pkg::coord_t a_z_i,
  input  tis_pkg::coord_t a_value_i,
  input  tis_pkg::coord_t b_x_i,
  input  tis_pkg::coord_t b_y_i,
  input  tis_pkg::coord_t b_z_i,
  input  tis_pkg::coord_t b_value_i,
  input  tis_pkg::coord_t c_x_i,
  input  tis_pkg::coord_t c_y_i,
  input  tis_pkg::coord_t c_z_i,
  input  tis_pkg::coord_t c_value_i,
  output logic            done_o,
  output tis_pkg::coord_t start_x_o,
  output tis_pkg::coord_t start_y_o,
  output tis_pkg::coord_t start_z_o,
  output tis_pkg::coord_t end_x_o,
  output tis_pkg::coord_t end_y_o,
  output tis_pkg::coord_t end_z_o
);
  import tis_pkg::*;

  coord_t                level_q;
  vertex_t [2:0]         vtx;
  logic                  cls_vld, itp_vld, div_vld;
  xing_t   [1:0]         seg;
  lane_t   [NumLanes-1:0] itp_lanes, div_lanes;
  logic                  done_q;
  coord_t  [NumLanes-1:0] res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (iso_level_we_i) begin
      level_q <= iso_level_i;
    end
  end

  assign vtx[0] = '{x: a_x_i, y: a_y_i, z: a_z_i, value: a_value_i};
  assign vtx[1] = '{x: b_x_i, y: b_y_i, z: b_z_i, value: b_value_i};
  assign vtx[2] = '{x: c_x_i, y: c_y_i, z: c_z_i, value: c_value_i};

  tis_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start && !busy),
    .level_i (level_q),
    .vtx_i   (vtx),
    .vld_o   (cls_vld),
    .seg_o   (seg)
  );

  tis_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (cls_vld),
    .seg_i   (seg),
    .vld_o   (itp_vld),
    .lanes_o (itp_lanes)
  );

  tis_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (itp_vld),
    .lanes_i (itp_lanes),
    .vld_o   (div_vld),
    .lanes_o (div_lanes)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_vld;
    end
  end

  // The quotient lies between the two end coordinates, so truncation is exact.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      res_q[l] <= div_lanes[l].neg ? coord_t'(-div_lanes[l].quo)
                                   : coord_t'(div_lanes[l].quo);
    end
  end

  assign done_o    = done_q;
  assign start_x_o = res_q[0];
  assign start_y_o = res_q[1];
  assign start_z_o = res_q[2];
  assign end_x_o   = res_q[3];
  assign end_y_o   = res_q[4];
  assign end_z_o   = res_q[5];

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Latency))
    else $error("segment without an accepted triangle");

  a_flat_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && a_value_i == level_q && b_value_i == level_q && c_value_i == level_q)
      |-> ##Latency !done_o)
    else $error("segment from a triangle lying on the level");

  a_edge_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && a_value_i == level_q && b_value_i != level_q && c_value_i == level_q)
      |-> ##Latency (done_o && start_x_o == $past(a_x_i, Latency)
                     && end_z_o == $past(c_z_i, Latency)))
    else $error("shared edge not passed through exactly");

endmodule

// ===== tb/triangle_isoline_segment_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_isoline_segment_tb
// Drives triangles into the isoline segment extractor, predicts each segment
// in the testbench, and compares every strobed segment with the oldest
// prediction. Directed corner triangles come first, then directed and random
// ones under several iso levels.
// ----------------------------------------------------------------------------
module triangle_isoline_segment_tb;
  import tis_pkg::*;

  localparam int unsigned MaxCycles = 400000;
  localparam int unsigned Drain     = Latency + 10;

  typedef struct packed {
    coord_t sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef enum int {
    ClsOn,
    ClsAbove,
    ClsBelow
  } side_e;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  logic     iso_level_we_i;
  coord_t   iso_level_i;
  vertex_t  vtx_a, vtx_b, vtx_c;
  logic     done_o;
  coord_t   start_x_o, start_y_o, start_z_o, end_x_o, end_y_o, end_z_o;

  segment_t segments_due[$];
  logic signed [63:0] level_q;
  int unsigned cycle_cnt;
  int unsigned mismatches;

  triangle_isoline_segment u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .iso_level_we_i (iso_level_we_i),
    .iso_level_i    (iso_level_i),
    .a_x_i          (vtx_a.x),
    .a_y_i          (vtx_a.y),
    .a_z_i          (vtx_a.z),
    .a_value_i      (vtx_a.value),
    .b_x_i          (vtx_b.x),
    .b_y_i          (vtx_b.y),
    .b_z_i          (vtx_b.z),
    .b_value_i      (vtx_b.value),
    .c_x_i          (vtx_c.x),
    .c_y_i          (vtx_c.y),
    .c_z_i          (vtx_c.z),
    .c_value_i      (vtx_c.value),
    .done_o         (done_o),
    .start_x_o      (start_x_o),
    .start_y_o      (start_y_o),
    .start_z_o      (start_z_o),
    .end_x_o        (end_x_o),
    .end_y_o        (end_y_o),
    .end_z_o        (end_z_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic signed [63:0] round_div(logic signed [63:0] n,
                                                   logic signed [63:0] d);
    logic signed [63:0] mag;
    logic signed [63:0] q;
    mag = (n < 0) ? -n : n;
    q   = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic side_e side_of(coord_t v);
    logic signed [63:0] s;
    s = v;
    if (s == level_q) return ClsOn;
    if (s > level_q) return ClsAbove;
    return ClsBelow;
  endfunction

  function automatic logic signed [63:0] weight(coord_t v);
    logic signed [63:0] s;
    s = v;
    return (s > level_q) ? s - level_q : level_q - s;
  endfunction

  // Interpolated crossing point on the edge p -> q, all three axes.
  function automatic logic [71:0] edge_cross(vertex_t p, vertex_t q);
    logic signed [63:0] wp, wq, den;
    logic [71:0] r;
    wp  = weight(p.value);
    wq  = weight(q.value);
    den = wp + wq;
    if (den == 0) den = 1;
    r[71:48] = coord_t'(round_div(64'(signed'(p.x)) * wq + 64'(signed'(q.x)) * wp, den));
    r[47:24] = coord_t'(round_div(64'(signed'(p.y)) * wq + 64'(signed'(q.y)) * wp, den));
    r[23:0]  = coord_t'(round_div(64'(signed'(p.z)) * wq + 64'(signed'(q.z)) * wp, den));
    return r;
  endfunction

  // Returns 1 and the segment when the triangle cuts the iso level.
  function automatic bit predict_segment(vertex_t v [3], output segment_t seg);
    side_e cls [3];
    int n_on, n_above, n_below, pick, o1, o2;
    logic [71:0] s, e;
    n_on = 0; n_above = 0; n_below = 0; pick = -1;
    for (int i = 0; i < 3; i++) begin
      cls[i] = side_of(v[i].value);
      if (cls[i] == ClsOn) n_on++;
      else if (cls[i] == ClsAbove) n_above++;
      else n_below++;
    end
    seg = '0;
    if (n_on == 2) begin
      for (int i = 2; i >= 0; i--) if (cls[i] != ClsOn) pick = i;
    end else if (n_on == 1 && n_above == 1) begin
      for (int i = 2; i >= 0; i--) if (cls[i] == ClsOn) pick = i;
    end else if (n_on == 0 && n_below == 1) begin
      for (int i = 2; i >= 0; i--) if (cls[i] == ClsBelow) pick = i;
    end else if (n_on == 0 && n_above == 1) begin
      for (int i = 2; i >= 0; i--) if (cls[i] == ClsAbove) pick = i;
    end
    if (pick < 0) return 0;
    o1 = (pick == 0) ? 1 : 0;
    o2 = (pick == 2) ? 1 : 2;
    if (n_on == 2) begin
      s = {v[o1].x, v[o1].y, v[o1].z};
      e = {v[o2].x, v[o2].y, v[o2].z};
    end else if (n_on == 1) begin
      s = {v[pick].x, v[pick].y, v[pick].z};
      e = edge_cross(v[o1], v[o2]);
    end else begin
      s = edge_cross(v[pick], v[o1]);
      e = edge_cross(v[pick], v[o2]);
    end
    seg = {s, e};
    return 1;
  endfunction

  // Without a gap start stays high, so the next transaction follows directly.
  task automatic wait_gap();
    int n;
    if ($urandom_range(0, 3) != 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_triangle(vertex_t a, vertex_t b, vertex_t c);
    vertex_t v [3];
    segment_t seg;
    v[0] = a; v[1] = b; v[2] = c;
    vtx_a <= a; vtx_b <= b; vtx_c <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (predict_segment(v, seg)) segments_due = {segments_due, seg};
    @(negedge clk_i);
    wait_gap();
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (segments_due.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
  endtask

  task automatic set_level(coord_t lvl);
    wait_idle();
    iso_level_i    <= lvl;
    iso_level_we_i <= 1'b1;
    @(negedge clk_i);
    iso_level_we_i <= 1'b0;
    level_q = lvl;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(24'h7FFFFF);
      1: return coord_t'(24'h800000);
      2: return coord_t'($urandom_range(0, 255) - 128);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Scalars are kept near the level most of the time so that cuts are common.
  function automatic coord_t rand_scalar();
    logic signed [63:0] s;
    case ($urandom_range(0, 9))
      0: return coord_t'(level_q);
      1: return coord_t'($urandom);
      2: return coord_t'(24'h7FFFFF);
      3: return coord_t'(24'h800000);
      default: begin
        s = level_q + $signed($urandom_range(0, 2000)) - 1000;
        if (s > 64'sd8388607) s = 64'sd8388607;
        if (s < -64'sd8388608) s = -64'sd8388608;
        return coord_t'(s);
      end
    endcase
  endfunction

  function automatic vertex_t mk(coord_t x, coord_t y, coord_t z, coord_t s);
    vertex_t v;
    v.x = x; v.y = y; v.z = z; v.value = s;
    return v;
  endfunction

  function automatic vertex_t rand_vertex();
    return mk(rand_coord(), rand_coord(), rand_coord(), rand_scalar());
  endfunction

  task automatic test_directed();
    coord_t mx, mn, l, hi, lo;
    mx = coord_t'(24'h7FFFFF);
    mn = coord_t'(24'h800000);
    l  = coord_t'(level_q);
    hi = coord_t'(level_q + 5);
    lo = coord_t'(level_q - 3);
    // Lone vertex below, then lone vertex above, at each position.
    send_triangle(mk(mx, mn, 0, lo), mk(mn, mx, 7, hi), mk(0, 0, mx, hi));
    send_triangle(mk(mx, mn, 0, hi), mk(mn, mx, 7, lo), mk(3, 9, mn, hi));
    send_triangle(mk(mx, mx, mx, hi), mk(mn, mn, mn, hi), mk(1, 2, 3, lo));
    send_triangle(mk(mx, mn, 0, hi), mk(mn, mx, 7, lo), mk(0, 0, mx, lo));
    send_triangle(mk(-5, 5, 1, lo), mk(5, -5, 1, hi), mk(0, 1, 2, lo));
    send_triangle(mk(mn, mn, mn, lo), mk(mx, mx, mx, lo), mk(1, 1, 1, hi));
    // Rounding ties: weights 1 and 1 give half steps.
    send_triangle(mk(0, 1, -1, coord_t'(level_q - 1)), mk(1, 0, 2, coord_t'(level_q + 1)),
                  mk(3, -3, 0, coord_t'(level_q + 1)));
    // One on the level with the others straddling it.
    send_triangle(mk(9, 8, 7, l), mk(mx, mn, mx, hi), mk(mn, mx, mn, lo));
    send_triangle(mk(mn, 0, mx, lo), mk(9, 8, 7, l), mk(4, 4, 4, hi));
    send_triangle(mk(1, 2, 3, hi), mk(4, 5, 6, lo), mk(-7, -8, -9, l));
    // Two on the level, the shared edge comes out.
    send_triangle(mk(mx, mn, 1, l), mk(mn, mx, 2, l), mk(0, 0, 0, hi));
    send_triangle(mk(1, 2, 3, lo), mk(mx, mx, mx, l), mk(mn, mn, mn, l));
    send_triangle(mk(5, 6, 7, l), mk(8, 9, 10, hi), mk(11, 12, 13, l));
    // No segment.
    send_triangle(mk(1, 1, 1, l), mk(2, 2, 2, l), mk(3, 3, 3, l));
    send_triangle(mk(1, 1, 1, hi), mk(2, 2, 2, hi), mk(3, 3, 3, hi));
    send_triangle(mk(1, 1, 1, lo), mk(2, 2, 2, lo), mk(3, 3, 3, lo));
    send_triangle(mk(1, 1, 1, l), mk(2, 2, 2, hi), mk(3, 3, 3, hi));
    send_triangle(mk(1, 1, 1, lo), mk(2, 2, 2, l), mk(3, 3, 3, lo));
    // Extreme scalars against the level.
    send_triangle(mk(mx, mx, mx, mx), mk(mn, mn, mn, mn), mk(0, 0, 0, mn));
    send_triangle(mk(mn, mx, mn, mn), mk(mx, mn, mx, mx), mk(2, 2, 2, mx));
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_triangle(rand_vertex(), rand_vertex(), rand_vertex());
      if (i == n / 2) wait_idle();
    end
  endtask

  task automatic test_levels();
    set_level('0);
    test_directed();
    test_random(150);
    set_level(coord_t'(24'h7FFFFF));
    test_directed();
    test_random(60);
    set_level(coord_t'(24'h800000));
    test_directed();
    test_random(60);
    set_level(coord_t'(24'h001000));
    test_random(150);
    set_level(coord_t'($urandom));
    test_directed();
    test_random(150);
  endtask

  // Segment checker.
  always @(posedge clk_i) begin
    segment_t want, got;
    if (rst_ni && done_o) begin
      got = {start_x_o, start_y_o, start_z_o, end_x_o, end_y_o, end_z_o};
      if (segments_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %h", got);
      end else begin
        want = segments_due.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("segment mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cycle_cnt = 0;
    mismatches = 0;
    level_q = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    iso_level_we_i = 1'b0;
    iso_level_i = '0;
    vtx_a = '0; vtx_b = '0; vtx_c = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Reset level is zero: run once before any write.
    test_directed();
    test_levels();
    wait_idle();
    if (mismatches == 0 && segments_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
